>>> src/image_crc32_with_masked_field_assert.svh
// Assertion macros shared by the image CRC checker.
`ifndef IMAGE_CRC32_WITH_MASKED_FIELD_ASSERT_SVH
`define IMAGE_CRC32_WITH_MASKED_FIELD_ASSERT_SVH

// Whenever the condition holds, the consequence holds in the same cycle.
`define ICM_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("image crc check failed in the same cycle");

// Whenever the condition holds, the consequence holds in the next cycle.
`define ICM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("image crc check failed one cycle later");

`endif

>>> src/icm_pkg.sv
// Types, constants and the CRC byte step shared by the image CRC checker.
package icm_pkg;

    localparam int ADDR_BITS    = 24;
    localparam int OFFSET_BITS  = 24;
    localparam int CRC_BITS     = 32;
    localparam int CFG_IDX_BITS = 1;
    // Compare width: holds both address and offset plus the field length without wrap.
    localparam int CMP_BITS     = ((ADDR_BITS > OFFSET_BITS) ? ADDR_BITS : OFFSET_BITS) + 1;

    localparam logic [CRC_BITS-1:0] CRC_POLY_REFLECTED = 32'hEDB8_8320;
    localparam logic [CRC_BITS-1:0] CRC_ALL_ONES       = 32'hFFFF_FFFF;
    localparam logic [CMP_BITS-1:0] CRC_FIELD_BYTES    = CMP_BITS'(4);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CRC_FIELD_OFFSET = 1'b0,
        CFG_EXPECTED_CRC     = 1'b1
    } t_cfg_index;

    // Word held between the input stage and the CRC stage.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_stage;

    // One reflected CRC-32 step over one byte, one bit per iteration.
    function automatic logic [CRC_BITS-1:0] crc_byte(input logic [CRC_BITS-1:0] crc_in,
                                                     input logic [7:0] b);
        logic [CRC_BITS-1:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFLECTED;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> src/icm_front.sv
// Input register with the byte address counter and the stored-field masking.
module icm_front
    import icm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_data,
    input  logic                   i_last,
    input  logic                   i_advance,
    input  logic [OFFSET_BITS-1:0] i_field_offset,
    output logic                   o_ready,
    output t_stage                 o_stage
);

    t_stage                r_stage;
    t_stage                n_stage;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [ADDR_BITS-1:0]  n_addr;
    logic [CMP_BITS-1:0]   addr_ext;
    logic [CMP_BITS-1:0]   off_ext;
    logic                  in_field;
    logic                  accept;

    assign o_ready = !r_stage.valid || i_advance;
    assign accept  = i_valid && o_ready;

    assign addr_ext = {{(CMP_BITS-ADDR_BITS){1'b0}}, r_addr};
    assign off_ext  = {{(CMP_BITS-OFFSET_BITS){1'b0}}, i_field_offset};
    assign in_field = (addr_ext >= off_ext) && (addr_ext < off_ext + CRC_FIELD_BYTES);

    always_comb begin
        n_stage = r_stage;
        n_addr  = r_addr;
        if (accept) begin
            n_stage.valid = 1'b1;
            n_stage.data  = in_field ? 8'd0 : i_data;
            n_stage.last  = i_last;
            n_addr        = i_last ? '0 : r_addr + 1'b1;
        end else if (i_advance) begin
            n_stage.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
            r_addr        <= '0;
        end else begin
            r_stage.valid <= n_stage.valid;
            r_addr        <= n_addr;
        end
        r_stage.data <= n_stage.data;
        r_stage.last <= n_stage.last;
    end

    assign o_stage = r_stage;

endmodule

>>> src/icm_core.sv
// Running CRC register and the result register with its compare flag.
module icm_core
    import icm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_stage              i_stage,
    input  logic [CRC_BITS-1:0] i_expected,
    input  logic                i_out_ready,
    output logic                o_advance,
    output logic                o_out_valid,
    output logic [CRC_BITS-1:0] o_out_crc,
    output logic                o_out_match
);

    logic [CRC_BITS-1:0] r_crc;
    logic [CRC_BITS-1:0] n_crc;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [CRC_BITS-1:0] r_out_crc;
    logic [CRC_BITS-1:0] n_out_crc;
    logic                r_out_match;
    logic                n_out_match;
    logic [CRC_BITS-1:0] step_crc;
    logic [CRC_BITS-1:0] final_crc;

    // A last byte waits here only while an untaken result fills the output register.
    assign o_advance = i_stage.valid && (!i_stage.last || !r_out_valid || i_out_ready);

    assign step_crc  = crc_byte(r_crc, i_stage.data);
    assign final_crc = step_crc ^ CRC_ALL_ONES;

    always_comb begin
        n_crc       = r_crc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_crc   = r_out_crc;
        n_out_match = r_out_match;
        if (o_advance) begin
            if (i_stage.last) begin
                n_crc       = CRC_ALL_ONES;
                n_out_valid = 1'b1;
                n_out_crc   = final_crc;
                n_out_match = (final_crc == i_expected);
            end else begin
                n_crc = step_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_ALL_ONES;
            r_out_valid <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
        r_out_crc   <= n_out_crc;
        r_out_match <= n_out_match;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_crc   = r_out_crc;
    assign o_out_match = r_out_match;

endmodule

>>> src/image_crc32_with_masked_field.sv
// Image CRC-32 checker top level: configuration registers, input stage and CRC stage.
// The block takes one image byte per cycle and keeps a reflected CRC-32 over it (preset
// and output XOR all ones); the four bytes at the configured offset enter the CRC as
// zero. The next image may follow in the very next cycle after the byte marked tlast
// is taken; a result word (final CRC in tdata, match flag in tuser) leaves through the
// output register once that byte has passed the CRC stage. The single-byte CRC step
// between the input register and the CRC register sets the one-byte-per-cycle rate;
// input is held off only while a last byte waits behind a result word that has not been
// taken. Configuration writes are always accepted and should be made between images.
`include "image_crc32_with_masked_field_assert.svh"

module image_crc32_with_masked_field
    import icm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration write channel.
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CRC_BITS-1:0]     i_cfg_data,
    // Image bytes.
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,   // [7:0] byte_value
    input  logic                    s_axis_tlast,
    // Results.
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [CRC_BITS-1:0]     m_axis_tdata,   // [31:0] crc_result
    output logic                    m_axis_tuser    // [0] crc_matches
);

    logic [OFFSET_BITS-1:0] r_field_offset;
    logic [CRC_BITS-1:0]    r_expected;
    t_stage                 stage;
    logic                   advance;
    logic                   cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_offset <= '0;
            r_expected     <= '0;
        end else if (cfg_write) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CRC_FIELD_OFFSET: r_field_offset <= i_cfg_data[OFFSET_BITS-1:0];
                CFG_EXPECTED_CRC:     r_expected     <= i_cfg_data;
                default:              ;
            endcase
        end
    end

    icm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .i_data         (s_axis_tdata),
        .i_last         (s_axis_tlast),
        .i_advance      (advance),
        .i_field_offset (r_field_offset),
        .o_ready        (s_axis_tready),
        .o_stage        (stage)
    );

    icm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (stage),
        .i_expected  (r_expected),
        .i_out_ready (m_axis_tready),
        .o_advance   (advance),
        .o_out_valid (m_axis_tvalid),
        .o_out_crc   (m_axis_tdata),
        .o_out_match (m_axis_tuser)
    );

    // A held last byte behind an untaken result must block new bytes.
    `ICM_ASSERT_NOW(a_block_on_full, i_clk, i_rst_n,
        stage.valid && stage.last && m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    // A result word appears only after a last byte moved through the CRC stage.
    `ICM_ASSERT_NOW(a_result_from_last, i_clk, i_rst_n,
        $rose(m_axis_tvalid), $past(advance && stage.last))
    // A last byte passing the CRC stage always produces a result word.
    `ICM_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n,
        advance && stage.last, m_axis_tvalid)
    // The CRC stage moves only a word that is there.
    `ICM_ASSERT_NOW(a_advance_needs_word, i_clk, i_rst_n, advance, stage.valid)

endmodule
